@@ hdl/gdb_pkg.sv @@
// ----------------------------------------------------------------------------
// Glyph downscale blitter package
// Shared types and constants for the glyph downscale blitter modules.
// ----------------------------------------------------------------------------
`default_nettype none

package gdb_pkg;

    localparam int SCALE_W     = 17;
    localparam int INV_SCALE_W = 20;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 20;
    localparam int ACC_W       = 28;
    localparam int ORIGIN_W    = 13;
    localparam int ADDR_W      = 18;
    localparam int IN_TDATA_W  = 72;
    localparam int OUT_TDATA_W = 24;
    localparam int PROD_SIDE_W = 25;
    localparam int PROD_BEAR_W = 27;
    localparam int Q_FRAC      = 16;

    // Item kinds carried in tuser.
    localparam logic ACTION_HEADER = 1'b0;
    localparam logic ACTION_BITMAP = 1'b1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE     = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_SCALE = 1'b1;

    localparam logic [3:0]  NIBBLE_MASK = 4'hF;
    localparam logic [3:0]  LEVEL_MAX   = 4'd15;
    localparam logic [16:0] SCALE_ONE   = 17'd65536;
    localparam logic [19:0] INV_ONE     = 20'd65536;
    localparam logic [15:0] Q_ROUND     = 16'hFFFF;

    // Input item after the first register, with the bearing and size products.
    typedef struct packed {
        logic                      action;
        logic [7:0]                glyph_width;
        logic [7:0]                glyph_height;
        logic [11:0]               start_x;
        logic [11:0]               baseline_y;
        logic [7:0]                bitmap_byte;
        logic [PROD_SIDE_W-1:0]    prod_width;
        logic [PROD_SIDE_W-1:0]    prod_height;
        logic [PROD_BEAR_W-1:0]    prod_left;
        logic [PROD_BEAR_W-1:0]    prod_top;
    } t_item;

    // One framebuffer pixel write.
    typedef struct packed {
        logic [ADDR_W-1:0] byte_address;
        logic              odd_pixel;
        logic [3:0]        pixel_level;
        logic              last_of_run;
    } t_pix;

endpackage

`default_nettype wire

@@ hdl/gdb_input_stage.sv @@
// ----------------------------------------------------------------------------
// Glyph downscale blitter input stage
// Input register; forms the size and bearing products against the scale.
// ----------------------------------------------------------------------------
`default_nettype none

module gdb_input_stage
    import gdb_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_tvalid,
    input  wire logic [IN_TDATA_W-1:0] i_tdata,
    input  wire logic                  i_tuser,
    input  wire logic [SCALE_W-1:0]    i_scale,
    input  wire logic                  i_take,
    output logic                       o_tready,
    output logic                       o_valid,
    output t_item                      o_item
);

    logic        r_valid;
    t_item       r_item;
    t_item       n_item;
    logic [8:0]  w_left;
    logic [8:0]  w_top;
    logic signed [PROD_BEAR_W-1:0] w_scale_s;

    assign o_tready = !r_valid || i_take;
    assign w_left   = i_tdata[24:16];
    assign w_top    = i_tdata[33:25];
    assign w_scale_s = $signed({{(PROD_BEAR_W-SCALE_W){1'b0}}, i_scale});

    always_comb begin
        n_item.action       = i_tuser;
        n_item.glyph_width  = i_tdata[7:0];
        n_item.glyph_height = i_tdata[15:8];
        n_item.start_x      = i_tdata[45:34];
        n_item.baseline_y   = i_tdata[57:46];
        n_item.bitmap_byte  = i_tdata[65:58];
        n_item.prod_width   = PROD_SIDE_W'(i_tdata[7:0]) * PROD_SIDE_W'(i_scale);
        n_item.prod_height  = PROD_SIDE_W'(i_tdata[15:8]) * PROD_SIDE_W'(i_scale);
        n_item.prod_left    = PROD_BEAR_W'(PROD_BEAR_W'($signed(w_left)) * w_scale_s);
        n_item.prod_top     = PROD_BEAR_W'(PROD_BEAR_W'($signed(w_top)) * w_scale_s);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_tvalid && o_tready) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_tvalid && o_tready) begin
            r_item <= n_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

`default_nettype wire

@@ hdl/gdb_glyph_engine.sv @@
// ----------------------------------------------------------------------------
// Glyph downscale blitter engine
// Glyph state, nearest-neighbour row and column selection, pixel writes.
// ----------------------------------------------------------------------------
`default_nettype none

module gdb_glyph_engine
    import gdb_pkg::*;
#(
    parameter int SCREEN_WIDTH   = 960,
    parameter int SCREEN_HEIGHT  = 540,
    parameter int MAX_GLYPH_SIDE = 255
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_go,
    input  wire t_item                  i_item,
    input  wire logic [INV_SCALE_W-1:0] i_inv_scale,
    output logic [1:0]                  o_res_cnt,
    output t_pix                        o_res0,
    output t_pix                        o_res1
);

    localparam int HALF_W = SCREEN_WIDTH / 2;
    localparam int POS_W  = 15;
    localparam int MUL_W  = 25;

    logic [7:0]          r_width, r_height, r_bpr, r_dest_w, r_dest_h;
    logic [ORIGIN_W-1:0] r_org_x, r_org_y;
    logic [7:0]          r_sbc, r_srow, r_dcol, r_drow;
    logic [ACC_W-1:0]    r_acc_c, r_acc_r;

    logic [7:0]          n_width, n_height, n_bpr, n_dest_w, n_dest_h;
    logic [ORIGIN_W-1:0] n_org_x, n_org_y;
    logic [7:0]          n_sbc, n_srow, n_dcol, n_drow;
    logic [ACC_W-1:0]    n_acc_c, n_acc_r;

    logic [9:0]          w_ceil_w, w_ceil_h;
    logic [7:0]          w_side_w, w_side_h;
    logic signed [PROD_BEAR_W:0] w_top_rnd;
    logic signed [ORIGIN_W-1:0]  w_floor_l, w_ceil_t;

    logic                w_live, w_row_hit, w_cond0, w_cond1, w_emit0, w_emit1;
    logic [8:0]          w_sxp0, w_sxp1, w_sbc_inc;
    logic [7:0]          w_dcol1, w_dcol_end;
    logic [ACC_W-1:0]    w_acc_c1, w_acc_c_end;
    logic [3:0]          w_nib0, w_nib1;
    logic signed [POS_W-1:0] w_x0, w_x1, w_y;
    t_pix                w_pix0, w_pix1;

    function automatic logic [7:0] side_limit(input logic [9:0] d);
        logic [7:0] v;
        begin
            if (d == 10'd0) begin
                v = 8'd1;
            end else if (d > 10'(MAX_GLYPH_SIDE)) begin
                v = 8'(MAX_GLYPH_SIDE);
            end else begin
                v = d[7:0];
            end
            return v;
        end
    endfunction

    function automatic logic on_screen(input logic signed [POS_W-1:0] x,
                                       input logic signed [POS_W-1:0] y);
        return (x >= 0) && (x < $signed(POS_W'(SCREEN_WIDTH))) &&
               (y >= 0) && (y < $signed(POS_W'(SCREEN_HEIGHT)));
    endfunction

    function automatic t_pix make_pix(input logic signed [POS_W-1:0] x,
                                      input logic signed [POS_W-1:0] y,
                                      input logic [3:0] nib);
        t_pix p;
        logic [MUL_W-1:0] row_base;
        begin
            row_base       = MUL_W'(y[12:0]) * MUL_W'(HALF_W);
            p.byte_address = ADDR_W'(row_base + MUL_W'(x[12:1]));
            p.odd_pixel    = x[0];
            p.pixel_level  = LEVEL_MAX - nib;
            p.last_of_run  = 1'b0;
            return p;
        end
    endfunction

    // Header arithmetic: destination sizes and the scaled bearings.
    always_comb begin
        w_ceil_w  = 10'((26'(i_item.prod_width) + 26'(Q_ROUND)) >> Q_FRAC);
        w_ceil_h  = 10'((26'(i_item.prod_height) + 26'(Q_ROUND)) >> Q_FRAC);
        w_side_w  = side_limit(w_ceil_w);
        w_side_h  = side_limit(w_ceil_h);
        w_floor_l = ORIGIN_W'($signed(i_item.prod_left) >>> Q_FRAC);
        w_top_rnd = (PROD_BEAR_W+1)'($signed(i_item.prod_top)) +
                    $signed({{(PROD_BEAR_W-15){1'b0}}, Q_ROUND});
        w_ceil_t  = ORIGIN_W'(w_top_rnd >>> Q_FRAC);
    end

    // Byte path: both nibbles of the byte are tried in one pass.
    always_comb begin
        w_live    = (r_bpr != 8'd0) && (r_srow < r_height);
        w_row_hit = (r_drow < r_dest_h) && (r_acc_r[ACC_W-1:Q_FRAC] == 12'(r_srow));
        w_nib0    = i_item.bitmap_byte[3:0] & NIBBLE_MASK;
        w_nib1    = i_item.bitmap_byte[7:4];
        w_sxp0    = {r_sbc, 1'b0};
        w_sxp1    = {r_sbc, 1'b1};

        w_cond0   = w_row_hit && (w_sxp0 < 9'(r_width)) && (r_dcol < r_dest_w) &&
                    (r_acc_c[ACC_W-1:Q_FRAC] == 12'(w_sxp0));
        w_dcol1   = w_cond0 ? r_dcol + 8'd1 : r_dcol;
        w_acc_c1  = w_cond0 ? r_acc_c + ACC_W'(i_inv_scale) : r_acc_c;

        w_cond1   = w_row_hit && (w_sxp1 < 9'(r_width)) && (w_dcol1 < r_dest_w) &&
                    (w_acc_c1[ACC_W-1:Q_FRAC] == 12'(w_sxp1));
        w_dcol_end  = w_cond1 ? w_dcol1 + 8'd1 : w_dcol1;
        w_acc_c_end = w_cond1 ? w_acc_c1 + ACC_W'(i_inv_scale) : w_acc_c1;

        w_x0 = POS_W'($signed(r_org_x)) + $signed(POS_W'(r_dcol));
        w_x1 = POS_W'($signed(r_org_x)) + $signed(POS_W'(w_dcol1));
        w_y  = POS_W'($signed(r_org_y)) + $signed(POS_W'(r_drow));

        w_emit0 = w_cond0 && (w_nib0 != 4'd0) && on_screen(w_x0, w_y);
        w_emit1 = w_cond1 && (w_nib1 != 4'd0) && on_screen(w_x1, w_y);
        w_pix0  = make_pix(w_x0, w_y, w_nib0);
        w_pix1  = make_pix(w_x1, w_y, w_nib1);
        w_sbc_inc = 9'(r_sbc) + 9'd1;
    end

    always_comb begin
        n_width  = r_width;
        n_height = r_height;
        n_bpr    = r_bpr;
        n_dest_w = r_dest_w;
        n_dest_h = r_dest_h;
        n_org_x  = r_org_x;
        n_org_y  = r_org_y;
        n_sbc    = r_sbc;
        n_srow   = r_srow;
        n_dcol   = r_dcol;
        n_drow   = r_drow;
        n_acc_c  = r_acc_c;
        n_acc_r  = r_acc_r;
        o_res_cnt = 2'd0;
        o_res0    = w_emit0 ? w_pix0 : w_pix1;
        o_res0.last_of_run = !(w_emit0 && w_emit1);
        o_res1    = w_pix1;
        o_res1.last_of_run = 1'b1;

        case (i_item.action)
            ACTION_HEADER: begin
                n_width  = i_item.glyph_width;
                n_height = i_item.glyph_height;
                n_bpr    = 8'((9'(i_item.glyph_width) + 9'd1) >> 1);
                if (i_item.glyph_width == 8'd0 || i_item.glyph_height == 8'd0) begin
                    n_dest_w = 8'd0;
                    n_dest_h = 8'd0;
                end else begin
                    n_dest_w = w_side_w;
                    n_dest_h = w_side_h;
                end
                n_org_x = ORIGIN_W'($signed(i_item.start_x)) + w_floor_l;
                n_org_y = ORIGIN_W'($signed(i_item.baseline_y)) - w_ceil_t;
                n_sbc   = 8'd0;
                n_srow  = 8'd0;
                n_dcol  = 8'd0;
                n_drow  = 8'd0;
                n_acc_c = '0;
                n_acc_r = '0;
            end
            ACTION_BITMAP: begin
                if (w_live) begin
                    o_res_cnt = 2'(w_emit0) + 2'(w_emit1);
                    if (w_sbc_inc >= 9'(r_bpr)) begin
                        // End of a source row: step to the next one.
                        n_sbc   = 8'd0;
                        n_srow  = r_srow + 8'd1;
                        n_dcol  = 8'd0;
                        n_acc_c = '0;
                        if (w_row_hit) begin
                            n_drow  = r_drow + 8'd1;
                            n_acc_r = r_acc_r + ACC_W'(i_inv_scale);
                        end
                    end else begin
                        n_sbc   = w_sbc_inc[7:0];
                        n_dcol  = w_dcol_end;
                        n_acc_c = w_acc_c_end;
                    end
                end
            end
            default: begin
                o_res_cnt = 2'd0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= '0;
            r_height <= '0;
            r_bpr    <= '0;
            r_dest_w <= '0;
            r_dest_h <= '0;
            r_org_x  <= '0;
            r_org_y  <= '0;
            r_sbc    <= '0;
            r_srow   <= '0;
            r_dcol   <= '0;
            r_drow   <= '0;
            r_acc_c  <= '0;
            r_acc_r  <= '0;
        end else if (i_go) begin
            r_width  <= n_width;
            r_height <= n_height;
            r_bpr    <= n_bpr;
            r_dest_w <= n_dest_w;
            r_dest_h <= n_dest_h;
            r_org_x  <= n_org_x;
            r_org_y  <= n_org_y;
            r_sbc    <= n_sbc;
            r_srow   <= n_srow;
            r_dcol   <= n_dcol;
            r_drow   <= n_drow;
            r_acc_c  <= n_acc_c;
            r_acc_r  <= n_acc_r;
        end
    end

endmodule

`default_nettype wire

@@ hdl/gdb_result_buffer.sv @@
// ----------------------------------------------------------------------------
// Glyph downscale blitter result buffer
// Two-entry output register that holds the pixel writes of one byte.
// ----------------------------------------------------------------------------
`default_nettype none

module gdb_result_buffer
    import gdb_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_push,
    input  wire logic [1:0] i_push_cnt,
    input  wire t_pix       i_res0,
    input  wire t_pix       i_res1,
    input  wire logic       i_ready,
    output logic            o_space,
    output logic            o_valid,
    output t_pix            o_data
);

    logic [1:0] r_cnt;
    t_pix       r_slot0;
    t_pix       r_slot1;

    // A byte's writes are only loaded once everything older has gone.
    assign o_space = (r_cnt == 2'd0) || (r_cnt == 2'd1 && i_ready);
    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_slot0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else if (i_push) begin
            r_cnt <= i_push_cnt;
        end else if (o_valid && i_ready) begin
            r_cnt <= r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot0 <= i_res0;
            r_slot1 <= i_res1;
        end else if (o_valid && i_ready) begin
            r_slot0 <= r_slot1;
        end
    end

`ifndef SYNTHESIS
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3)
        else $error("result buffer count out of range");

    a_push_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && i_push_cnt != 2'd0) |-> (r_cnt == 2'd0 || (r_cnt == 2'd1 && i_ready)))
        else $error("pixel writes loaded over pending results");

    a_pair_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && i_push_cnt == 2'd2) |=> (r_cnt == 2'd2))
        else $error("pair of pixel writes not held");
`endif

endmodule

`default_nettype wire

@@ hdl/glyph_downscale_blitter.sv @@
// ----------------------------------------------------------------------------
// Glyph downscale blitter
// Nearest-neighbour downscaler for 4-bit glyph bitmaps to framebuffer writes.
// ----------------------------------------------------------------------------
// Channel   Direction  Signals                          Content
// s_axis    in         tvalid tready tdata[71:0] tuser  header or bitmap byte
// m_axis    out        tvalid tready tdata[23:0] tlast  framebuffer pixel write
// cfg       in         i_cfg_we i_cfg_index i_cfg_data  scale registers
//
// A byte that writes both of its pixels sends them one after the other through the
// single output port; the next item is taken while the last write is being sent.
// An input transaction passes the input register and then the result buffer.
// Reset is synchronous and active low; it sets both scales to 1.0 and clears
// the glyph state, so bytes before the first header write nothing.
// A stalled output holds the input register, which then holds s_axis_tready low.
// ----------------------------------------------------------------------------
`default_nettype none

module glyph_downscale_blitter
    import gdb_pkg::*;
#(
    parameter int SCREEN_WIDTH   = 960,
    parameter int SCREEN_HEIGHT  = 540,
    parameter int MAX_GLYPH_SIDE = 255
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    // glyph_width[7:0], glyph_height[15:8], glyph_left[24:16], glyph_top[33:25],
    // start_x[45:34], baseline_y[57:46], bitmap_byte[65:58], zero[71:66]
    input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // action[0]
    input  wire logic                   s_axis_tuser,
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    // byte_address[17:0], odd_pixel[18], pixel_level[22:19], zero[23]
    output logic [OUT_TDATA_W-1:0]      m_axis_tdata,
    output logic                        m_axis_tlast,
    input  wire logic                   i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  i_cfg_data
);

    logic [SCALE_W-1:0]     r_scale_q16;
    logic [INV_SCALE_W-1:0] r_inv_scale_q16;

    logic       w_item_valid;
    t_item      w_item;
    logic       w_space;
    logic       w_go;
    logic [1:0] w_res_cnt;
    t_pix       w_res0;
    t_pix       w_res1;
    t_pix       w_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale_q16     <= SCALE_ONE;
            r_inv_scale_q16 <= INV_ONE;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_SCALE:     r_scale_q16     <= i_cfg_data[SCALE_W-1:0];
                CFG_INV_SCALE: r_inv_scale_q16 <= i_cfg_data[INV_SCALE_W-1:0];
                default: begin
                    r_scale_q16 <= r_scale_q16;
                end
            endcase
        end
    end

    assign w_go = w_item_valid && w_space;

    gdb_input_stage u_input (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_tvalid (s_axis_tvalid),
        .i_tdata  (s_axis_tdata),
        .i_tuser  (s_axis_tuser),
        .i_scale  (r_scale_q16),
        .i_take   (w_go),
        .o_tready (s_axis_tready),
        .o_valid  (w_item_valid),
        .o_item   (w_item)
    );

    gdb_glyph_engine #(
        .SCREEN_WIDTH   (SCREEN_WIDTH),
        .SCREEN_HEIGHT  (SCREEN_HEIGHT),
        .MAX_GLYPH_SIDE (MAX_GLYPH_SIDE)
    ) u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_go        (w_go),
        .i_item      (w_item),
        .i_inv_scale (r_inv_scale_q16),
        .o_res_cnt   (w_res_cnt),
        .o_res0      (w_res0),
        .o_res1      (w_res1)
    );

    gdb_result_buffer u_results (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (w_go),
        .i_push_cnt (w_res_cnt),
        .i_res0     (w_res0),
        .i_res1     (w_res1),
        .i_ready    (m_axis_tready),
        .o_space    (w_space),
        .o_valid    (m_axis_tvalid),
        .o_data     (w_out)
    );

    assign m_axis_tdata = {1'b0, w_out.pixel_level, w_out.odd_pixel, w_out.byte_address};
    assign m_axis_tlast = w_out.last_of_run;

endmodule

`default_nettype wire
